[rtl/cbcu_pkg.sv]
// shared types, constants and helpers for the counting bloom conservative update core
package cbcu_pkg;

    localparam int CELL_BITS  = 8;
    localparam int NUM_CELLS  = 65536;
    localparam int MAX_HASHES = 8;

    localparam int ADDR_BITS   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int INDEX_BITS  = 16;
    localparam int NUM_INDEXES = 8;
    localparam int SLOT_BITS   = 3;
    localparam int VALUE_BITS  = 8;
    localparam int HC_BITS     = 4;

    typedef logic [CELL_BITS-1:0]  cell_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [HC_BITS-1:0]    hcount_t;

    localparam cell_t CELL_MAX    = cell_t'((2 ** CELL_BITS) - 1);
    localparam addr_t LAST_ADDR   = addr_t'(NUM_CELLS - 1);
    localparam logic [INDEX_BITS-1:0] INDEX_MASK = INDEX_BITS'(NUM_CELLS - 1);

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_DECIDE,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        cell_t wdata;
        logic  re;
        addr_t raddr;
    } ram_req_t;

    typedef struct packed {
        logic clearing;
        logic idle;
        logic writing;
    } status_t;

    // store index from a hashed index, wrapped onto the store size
    function automatic addr_t reduce_index(input logic [INDEX_BITS-1:0] idx);
        return addr_t'(idx & INDEX_MASK);
    endfunction

    // occurrence saturated to the cell maximum
    function automatic cell_t clamp_occ(input logic [INDEX_BITS-1:0] occ);
        cell_t res;
        if (occ > INDEX_BITS'(CELL_MAX))
        begin
            res = CELL_MAX;
        end
        else
        begin
            res = cell_t'(occ);
        end
        return res;
    endfunction

    // slot of the last index in use, from the hash count register
    function automatic slot_t last_slot(input hcount_t hc);
        hcount_t n;
        n = hc;
        if (n == '0)
        begin
            n = hcount_t'(1);
        end
        if (n > hcount_t'(MAX_HASHES))
        begin
            n = hcount_t'(MAX_HASHES);
        end
        return slot_t'(n - hcount_t'(1));
    endfunction

    function automatic value_t to_value(input cell_t c);
        return value_t'(c);
    endfunction

endpackage

[rtl/cbcu_cell_ram.sv]
// single-port-write, single-port-read cell store with registered read data
module cbcu_cell_ram (
    input  logic               clk,
    input  cbcu_pkg::ram_req_t req,
    output cbcu_pkg::cell_t    rdata
);

    cbcu_pkg::cell_t mem [cbcu_pkg::NUM_CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

[rtl/cbcu_seq.sv]
// sequencer with the shared compare unit: clearing pass, reads, decision and write-back
module cbcu_seq (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [cbcu_pkg::INDEX_BITS*9-1:0]      s_tdata,
    input  logic                                   s_tuser,
    input  cbcu_pkg::hcount_t                      hash_count,
    output cbcu_pkg::ram_req_t                     ram_req,
    input  cbcu_pkg::cell_t                        ram_rdata,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output cbcu_pkg::cell_t                        res_value,
    output cbcu_pkg::status_t                      status
);

    cbcu_pkg::state_t state_reg, state_next;
    cbcu_pkg::addr_t  clr_reg, clr_next;
    cbcu_pkg::slot_t  cnt_reg, cnt_next;
    cbcu_pkg::slot_t  last_reg, last_next;
    logic             cmd_reg, cmd_next;
    cbcu_pkg::cell_t  occ_reg, occ_next;
    cbcu_pkg::cell_t  min_reg, min_next;
    cbcu_pkg::cell_t  res_reg, res_next;
    cbcu_pkg::addr_t  idx_reg [cbcu_pkg::NUM_INDEXES];
    cbcu_pkg::addr_t  idx_next [cbcu_pkg::NUM_INDEXES];
    cbcu_pkg::cell_t  old_reg [cbcu_pkg::NUM_INDEXES];
    cbcu_pkg::cell_t  old_next [cbcu_pkg::NUM_INDEXES];

    // the one comparator, shared by the min search, the decision and the write-back
    cbcu_pkg::cell_t  cmp_a, cmp_b;
    logic             cmp_lt;

    assign cmp_lt = cmp_a < cmp_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbcu_pkg::ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        cmd_reg  <= cmd_next;
        occ_reg  <= occ_next;
        min_reg  <= min_next;
        res_reg  <= res_next;
        idx_reg  <= idx_next;
        old_reg  <= old_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        cmd_next   = cmd_reg;
        occ_next   = occ_reg;
        min_next   = min_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        old_next   = old_reg;
        ram_req    = '0;
        s_tready   = 1'b0;
        res_valid  = 1'b0;
        cmp_a      = ram_rdata;
        cmp_b      = min_reg;

        case (state_reg)
            cbcu_pkg::ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + cbcu_pkg::addr_t'(1);
                if (clr_reg == cbcu_pkg::LAST_ADDR)
                begin
                    state_next = cbcu_pkg::ST_IDLE;
                end
            end
            cbcu_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next  = s_tuser;
                    occ_next  = cbcu_pkg::clamp_occ(s_tdata[cbcu_pkg::INDEX_BITS-1:0]);
                    last_next = cbcu_pkg::last_slot(hash_count);
                    min_next  = cbcu_pkg::CELL_MAX;
                    cnt_next  = '0;
                    for (int i = 0; i < cbcu_pkg::NUM_INDEXES; i++)
                    begin
                        idx_next[i] = cbcu_pkg::reduce_index(
                            s_tdata[cbcu_pkg::INDEX_BITS*(i+1) +: cbcu_pkg::INDEX_BITS]);
                    end
                    state_next = cbcu_pkg::ST_READ_ADDR;
                end
            end
            cbcu_pkg::ST_READ_ADDR:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = idx_reg[cnt_reg];
                state_next    = cbcu_pkg::ST_READ_DATA;
            end
            cbcu_pkg::ST_READ_DATA:
            begin
                cmp_a             = ram_rdata;
                cmp_b             = min_reg;
                old_next[cnt_reg] = ram_rdata;
                if (cmp_lt)
                begin
                    min_next = ram_rdata;
                end
                if (cnt_reg == last_reg)
                begin
                    state_next = cbcu_pkg::ST_DECIDE;
                end
                else
                begin
                    cnt_next   = cnt_reg + cbcu_pkg::slot_t'(1);
                    state_next = cbcu_pkg::ST_READ_ADDR;
                end
            end
            cbcu_pkg::ST_DECIDE:
            begin
                cmp_a    = min_reg;
                cmp_b    = occ_reg;
                cnt_next = '0;
                if ((cmd_reg == cbcu_pkg::CMD_SET) && cmp_lt)
                begin
                    res_next   = occ_reg;
                    state_next = cbcu_pkg::ST_WRITE;
                end
                else
                begin
                    res_next   = min_reg;
                    state_next = cbcu_pkg::ST_FINISH;
                end
            end
            cbcu_pkg::ST_WRITE:
            begin
                // only cells below the new count are raised
                cmp_a = old_reg[cnt_reg];
                cmp_b = occ_reg;
                if (cmp_lt)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = idx_reg[cnt_reg];
                    ram_req.wdata = occ_reg;
                end
                if (cnt_reg == last_reg)
                begin
                    state_next = cbcu_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + cbcu_pkg::slot_t'(1);
                end
            end
            cbcu_pkg::ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = cbcu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbcu_pkg::ST_CLEAR;
            end
        endcase
    end

    assign res_value = res_reg;
    assign status    = '{clearing: (state_reg == cbcu_pkg::ST_CLEAR),
                         idle:     (state_reg == cbcu_pkg::ST_IDLE),
                         writing:  (state_reg == cbcu_pkg::ST_WRITE)};

endmodule

[rtl/counting_bloom_conservative_update_core.sv]
// counting bloom filter core with conservative update: config register, output register
// flow: after the input transaction each index in use is read (address, then data) in turn,
// then a decision; a set that raises the minimum adds a write-back pass over the indexes,
// and the result is handed to the output register; no new transaction is taken until then
// reset: hash_count returns to 1 and a clearing pass zeroes all NUM_CELLS (65536) cells,
// one cell a cycle; s_tready stays low until it ends, config writes are taken
module counting_bloom_conservative_update_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wen,
    input  cbcu_pkg::hcount_t                      cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // occurrence, index_0, index_1, ... index_7
    input  logic [cbcu_pkg::INDEX_BITS*9-1:0]      s_tdata,
    // command
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // value
    output cbcu_pkg::value_t                       m_tdata
);

    cbcu_pkg::hcount_t  hash_count_reg;
    cbcu_pkg::ram_req_t ram_req;
    cbcu_pkg::cell_t    ram_rdata;
    cbcu_pkg::cell_t    res_value;
    cbcu_pkg::status_t  status;
    logic               res_valid;
    logic               res_ready;
    logic               m_tvalid_reg, m_tvalid_next;
    cbcu_pkg::value_t   m_tdata_reg, m_tdata_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg <= cbcu_pkg::hcount_t'(1);
        end
        else if (cfg_wen)
        begin
            hash_count_reg <= cfg_wdata;
        end
    end

    cbcu_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .hash_count (hash_count_reg),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_value  (res_value),
        .status     (status)
    );

    cbcu_cell_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // output register frees the sequencer once the result is parked
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = cbcu_pkg::to_value(res_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.clearing |-> !s_tready
    ) else $error("input accepted during clearing pass");

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("ready held after input transaction");

    a_no_write_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.idle |-> !ram_req.we
    ) else $error("cell store written while idle");

    a_write_back_sets_only: assert property (
        @(posedge clk) disable iff (!rst_n)
        (status.writing && ram_req.we) |-> (ram_req.wdata != '0)
    ) else $error("write-back of a zero count");

endmodule

[tb/cbcu_checker.sv]
`timescale 1ns / 100ps
// checker for the counting bloom core: mirrors the cell store and compares every result
module cbcu_checker
    import cbcu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  hcount_t                    cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [INDEX_BITS*9-1:0]    s_tdata,
    input  logic                       s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  value_t                     m_tdata,
    output int                         fail_count,
    output int                         pending
);

    localparam int unsigned CELL_TOP = (1 << CELL_BITS) - 1;

    logic [CELL_BITS-1:0] cells [NUM_CELLS];
    hcount_t hash_cnt = hcount_t'(1);
    value_t  expected_values [$];
    int      errors = 0;

    initial
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            cells[i] = '0;
        end
    end

    // min over the addressed cells; a set raises only the cells below the clamped occurrence
    function automatic value_t lookup_and_update(input logic cmd, input logic [15:0] occ,
                                                 input logic [INDEX_BITS*9-1:0] word);
        int          n;
        int unsigned addr [8];
        int unsigned old_v [8];
        int unsigned min_v;
        int unsigned target;
        int unsigned res;
        n = (hash_cnt == 0) ? 1 : ((hash_cnt > MAX_HASHES) ? MAX_HASHES : int'(hash_cnt));
        min_v = CELL_TOP;
        for (int k = 0; k < n; k++)
        begin
            addr[k]  = int'(word[16*(k+1) +: 16]) % NUM_CELLS;
            old_v[k] = int'(cells[addr[k]]);
            if (old_v[k] < min_v)
            begin
                min_v = old_v[k];
            end
        end
        if (cmd == CMD_QUERY)
        begin
            res = min_v;
        end
        else
        begin
            target = (occ > CELL_TOP) ? CELL_TOP : int'(occ);
            if (min_v >= target)
            begin
                res = min_v;
            end
            else
            begin
                // all reads above happen before any write, so repeated indexes are harmless
                for (int k = 0; k < n; k++)
                begin
                    if (old_v[k] < target)
                    begin
                        cells[addr[k]] = CELL_BITS'(target);
                    end
                end
                res = target;
            end
        end
        return value_t'(res & 8'hFF);
    endfunction

    always @(posedge clk)
    begin
        value_t want;
        if (!rst_n)
        begin
            hash_cnt = hcount_t'(1);
            expected_values.delete();
        end
        else
        begin
            if (cfg_wen)
            begin
                hash_cnt = cfg_wdata;
            end
            // pop before push so a stray result cannot consume a fresh expectation
            if (m_tvalid && m_tready)
            begin
                if (expected_values.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %0d",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (m_tdata !== want)
                    begin
                        errors++;
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_values.insert(expected_values.size(),
                                       lookup_and_update(s_tuser, s_tdata[15:0], s_tdata));
            end
        end
        pending    <= expected_values.size();
        fail_count <= errors;
    end

endmodule

[tb/counting_bloom_conservative_update_core_tb.sv]
`timescale 1ns / 100ps
// testbench top for the counting bloom core: clock, reset, stimulus and verdict
module counting_bloom_conservative_update_core_tb;
    import cbcu_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 700;
    localparam int SETTLE       = 40;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 80;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wen = 1'b0;
    hcount_t                 cfg_wdata = hcount_t'(1);
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [INDEX_BITS*9-1:0] s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    value_t                  m_tdata;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    bit          send_burst = 1'b0;
    bit          take_burst = 1'b0;
    bit          hold_request = 1'b0;
    logic [15:0] hot_pool [16];
    hcount_t     phase_counts [PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5,
                                           4'd2, 4'd7, 4'd4, 4'd6, 4'd12, 4'd8};

    counting_bloom_conservative_update_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cbcu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial
    begin
        int stall;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            else
            begin
                stall = take_burst ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    // index_0 sits in the lowest 16 bits of idx_word
    task automatic send_item(input logic cmd, input logic [15:0] occ,
                             input logic [127:0] idx_word);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= cmd;
        s_tdata  <= {idx_word, occ};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_hash_count(input hcount_t hc);
        cfg_wdata <= hc;
        cfg_wen   <= 1'b1;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [15:0] random_occurrence();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 12));
            1: return 16'($urandom_range(245, 270));
            2: return 16'($urandom);
            3: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd256;
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        logic [127:0] idx_word;
        logic         cmd;
        bit           hot;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, all eight indexes in use
        write_hash_count(hcount_t'(8));
        send_item(CMD_QUERY, 16'd0, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        send_item(CMD_SET, 16'd5, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        send_item(CMD_QUERY, 16'd0, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        // smaller occurrence than the stored minimum leaves the cells alone
        send_item(CMD_SET, 16'd3, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        send_item(CMD_SET, 16'hFFFF,
                  {16'd103, 16'd102, 16'd101, 16'd100, 16'd3, 16'd2, 16'd1, 16'd0});
        send_item(CMD_QUERY, 16'd0, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        send_item(CMD_SET, 16'd256, {8{16'hFFFF}});
        send_item(CMD_QUERY, 16'd0, {8{16'hFFFF}});
        send_item(CMD_SET, 16'd0, {8{16'd500}});
        send_item(CMD_SET, 16'd255,
                  {16'd204, 16'd200, 16'd203, 16'd200, 16'd202, 16'd200, 16'd201, 16'd200});
        send_item(CMD_SET, 16'd9,
                  {16'd102, 16'd101, 16'd7, 16'd6, 16'd5, 16'd4, 16'd1, 16'd0});
        send_item(CMD_QUERY, 16'd0,
                  {16'd102, 16'd101, 16'd7, 16'd6, 16'd5, 16'd4, 16'd1, 16'd0});
        send_item(CMD_SET, 16'hAAAA, {8{16'h5555}});
        send_item(CMD_QUERY, 16'h5555, {8{16'hAAAA}});

        // zero hash count behaves as one
        drain();
        write_hash_count(hcount_t'(0));
        send_item(CMD_SET, 16'd7, {{7{16'hFFFF}}, 16'd300});
        send_item(CMD_QUERY, 16'd0, {{7{16'd0}}, 16'd300});

        // hash count above the maximum behaves as eight
        drain();
        write_hash_count(hcount_t'(15));
        send_item(CMD_QUERY, 16'd0, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        send_item(CMD_SET, 16'd1, {16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd300});

        // random part: mostly a small hot set of cells so counts build up and collide
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_hash_count(phase_counts[p]);
            send_burst = ($urandom_range(0, 3) == 0);
            take_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 16; k++)
            begin
                hot_pool[k] = 16'($urandom);
            end
            hot_pool[0] = 16'h0000;
            hot_pool[1] = 16'hFFFF;
            if (p == 3)
            begin
                hold_request = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 6 && i == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                cmd = ($urandom_range(0, 4) < 2) ? CMD_QUERY : CMD_SET;
                hot = ($urandom_range(0, 6) != 0);
                for (int k = 0; k < 8; k++)
                begin
                    idx_word[16*k +: 16] = hot ? hot_pool[$urandom_range(0, 15)]
                                               : 16'($urandom);
                end
                send_item(cmd, random_occurrence(), idx_word);
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
